// ===== hdl/mlhd_pkg.sv =====
// ----------------------------------------------------------------------------
// mlhd_pkg: shared types, constants and lookup tables
// Bitrate and sample-rate tables plus the reciprocal constants used by the
// frame length divider of the Layer III header decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mlhd_pkg;

  // Version codes as they appear in the header.
  localparam logic [1:0] VER_CODE_V25  = 2'd0;
  localparam logic [1:0] VER_CODE_RSVD = 2'd1;
  localparam logic [1:0] VER_CODE_V2   = 2'd2;
  localparam logic [1:0] VER_CODE_V1   = 2'd3;

  // Version numbers as they are reported.
  localparam logic [1:0] VER_OUT_V1  = 2'd0;
  localparam logic [1:0] VER_OUT_V2  = 2'd1;
  localparam logic [1:0] VER_OUT_V25 = 2'd2;

  localparam logic [1:0] LAYER_III_CODE = 2'd1;
  localparam logic [1:0] MODE_MONO      = 2'd3;
  localparam logic [3:0] BRI_FREE       = 4'd0;
  localparam logic [3:0] BRI_BAD        = 4'd15;
  localparam logic [1:0] SRI_44K1       = 2'd0;
  localparam logic [1:0] SRI_48K        = 2'd1;
  localparam logic [1:0] SRI_32K        = 2'd2;
  localparam logic [1:0] SRI_RSVD       = 2'd3;

  localparam logic [10:0] SAMPLES_V1    = 11'd1152;
  localparam logic [10:0] SAMPLES_OTHER = 11'd576;

  // Frame length multipliers: bytes = kbps * mult / divisor.
  localparam logic [11:0] MULT_44K1     = 12'd1440;
  localparam logic [11:0] MULT_44K1_V25 = 12'd2880;
  localparam logic [11:0] MULT_48K      = 12'd3;
  localparam logic [11:0] MULT_48K_V25  = 12'd6;
  localparam logic [11:0] MULT_32K      = 12'd9;
  localparam logic [11:0] MULT_32K_V25  = 12'd18;

  // Division by 441 through a reciprocal: q = (n * RECIP_441) >> RECIP_SHIFT,
  // followed by a one-step remainder correction.
  localparam logic [8:0]  DIV_441     = 9'd441;
  localparam logic [19:0] RECIP_441   = 20'd608698;
  localparam int          RECIP_SHIFT = 28;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_HALF,
    DIV_BY_441
  } div_mode_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  version;
    logic [8:0]  kbps;
    logic [15:0] rate;
    logic [1:0]  chans;
    logic [10:0] samples;
    logic        pad;
  } hdr_info_t;

  function automatic logic [8:0] kbps_lookup(input logic is_v1, input logic [3:0] idx);
    logic [8:0] val;
    if (is_v1) begin
      case (idx)
        4'd1:    val = 9'd32;
        4'd2:    val = 9'd40;
        4'd3:    val = 9'd48;
        4'd4:    val = 9'd56;
        4'd5:    val = 9'd64;
        4'd6:    val = 9'd80;
        4'd7:    val = 9'd96;
        4'd8:    val = 9'd112;
        4'd9:    val = 9'd128;
        4'd10:   val = 9'd160;
        4'd11:   val = 9'd192;
        4'd12:   val = 9'd224;
        4'd13:   val = 9'd256;
        4'd14:   val = 9'd320;
        default: val = 9'd0;
      endcase
    end else begin
      case (idx)
        4'd1:    val = 9'd8;
        4'd2:    val = 9'd16;
        4'd3:    val = 9'd24;
        4'd4:    val = 9'd32;
        4'd5:    val = 9'd40;
        4'd6:    val = 9'd48;
        4'd7:    val = 9'd56;
        4'd8:    val = 9'd64;
        4'd9:    val = 9'd80;
        4'd10:   val = 9'd96;
        4'd11:   val = 9'd112;
        4'd12:   val = 9'd128;
        4'd13:   val = 9'd144;
        4'd14:   val = 9'd160;
        default: val = 9'd0;
      endcase
    end
    return val;
  endfunction

  function automatic logic [15:0] base_rate(input logic [1:0] sri);
    logic [15:0] val;
    case (sri)
      SRI_44K1: val = 16'd44100;
      SRI_48K:  val = 16'd48000;
      SRI_32K:  val = 16'd32000;
      default:  val = 16'd0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/mpeg_layer3_header_decode.sv =====
// ----------------------------------------------------------------------------
// mpeg_layer3_header_decode: MPEG audio Layer III frame header decoder
// Parses one 32-bit header word per transaction and reports version,
// bitrate, sample rate, channels, samples per frame and frame length.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one header word per transaction, the first
//   stream byte in bits 31..24. The master channel returns one result per
//   header, in order. A header that fails the sync, layer, version, bitrate
//   or sample-rate checks returns header_ok = 0 with every other field zero.
//   The block is a five-register pipeline: decode and table lookup, the
//   bitrate multiply, the reciprocal multiply for the 44.1 kHz family, the
//   quotient and remainder step, and the output register. m_tvalid and
//   m_tdata come straight from the output register, and one header is
//   taken every cycle while m_tready keeps the pipeline moving.
//   Each stage moves forward when the stage after it is empty or moving, so
//   bubbles close up. When the receiver holds m_tready low the pipeline
//   fills and then s_tready drops; nothing is lost or repeated.
//   Synchronous reset empties all stages; s_tready is high right after it.
// ----------------------------------------------------------------------------
`default_nettype none

module mpeg_layer3_header_decode (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] header_word
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] header_ok, [2:1] mpeg_version, [11:3] bitrate_kbps,
  // [27:12] sample_rate_hz, [29:28] channel_count, [40:30] frame_samples,
  // [51:41] frame_bytes, [55:52] zero
  output logic [55:0]      m_tdata
);
  import mlhd_pkg::*;

  // Stage valid bits and advance enables.
  logic v1, v2, v3, v4, v5;
  logic adv1, adv2, adv3, adv4, adv5;

  // Stage 1: decoded header.
  hdr_info_t   info1;
  logic [11:0] mult1;
  div_mode_t   dmode1;
  // Stage 2: numerator.
  hdr_info_t   info2;
  div_mode_t   dmode2;
  logic [18:0] num2;
  // Stage 3: reciprocal product.
  hdr_info_t   info3;
  div_mode_t   dmode3;
  logic [18:0] num3;
  logic [38:0] prod3;
  // Stage 4: quotient and correction.
  hdr_info_t   info4;
  logic [10:0] quot4;
  logic        corr4;
  // Stage 5: output register.
  hdr_info_t   info5;
  logic [10:0] bytes5;

  // Stage 1 decode.
  logic [1:0]  ver_code, layer_code, sri, mode;
  logic [3:0]  bri;
  logic        sync_ok;
  logic        is_v25;
  logic [15:0] brate;
  hdr_info_t   info1_next;
  logic [11:0] mult1_next;
  div_mode_t   dmode1_next;

  // Later stage logic.
  logic [20:0] num_full;
  logic [38:0] prod_next;
  logic [10:0] quot_div;
  logic [18:0] quot_back;
  logic [18:0] rem_full;
  logic [10:0] quot4_next;
  logic        corr4_next;
  logic [10:0] bytes5_next;

  assign adv5 = ~v5 | m_tready;
  assign adv4 = ~v4 | adv5;
  assign adv3 = ~v3 | adv4;
  assign adv2 = ~v2 | adv3;
  assign adv1 = ~v1 | adv2;
  assign s_tready = adv1;

  always_comb begin
    ver_code   = s_tdata[20:19];
    layer_code = s_tdata[18:17];
    bri        = s_tdata[15:12];
    sri        = s_tdata[11:10];
    mode       = s_tdata[7:6];
    sync_ok    = (s_tdata[31:21] == '1);
    is_v25     = (ver_code == VER_CODE_V25);
    brate      = base_rate(sri);

    info1_next.ok = sync_ok && (ver_code != VER_CODE_RSVD) &&
                    (layer_code == LAYER_III_CODE) && (bri != BRI_FREE) &&
                    (bri != BRI_BAD) && (sri != SRI_RSVD);
    info1_next.kbps  = kbps_lookup(ver_code == VER_CODE_V1, bri);
    info1_next.chans = (mode == MODE_MONO) ? 2'd1 : 2'd2;
    info1_next.pad   = s_tdata[9];

    case (ver_code)
      VER_CODE_V1: begin
        info1_next.version = VER_OUT_V1;
        info1_next.rate    = brate;
        info1_next.samples = SAMPLES_V1;
      end
      VER_CODE_V2: begin
        info1_next.version = VER_OUT_V2;
        info1_next.rate    = brate >> 1;
        info1_next.samples = SAMPLES_OTHER;
      end
      default: begin
        info1_next.version = VER_OUT_V25;
        info1_next.rate    = brate >> 2;
        info1_next.samples = SAMPLES_OTHER;
      end
    endcase

    // The version scaling of rate and samples cancels except for MPEG-2.5,
    // whose quarter rate over half samples doubles the multiplier.
    case (sri)
      SRI_48K: begin
        mult1_next  = is_v25 ? MULT_48K_V25 : MULT_48K;
        dmode1_next = DIV_NONE;
      end
      SRI_32K: begin
        mult1_next  = is_v25 ? MULT_32K_V25 : MULT_32K;
        dmode1_next = DIV_HALF;
      end
      default: begin
        mult1_next  = is_v25 ? MULT_44K1_V25 : MULT_44K1;
        dmode1_next = DIV_BY_441;
      end
    endcase
  end

  always_comb begin
    num_full  = 21'(info1.kbps) * 21'(mult1);
    prod_next = 39'(num2) * 39'(RECIP_441);

    quot_div  = prod3[38:RECIP_SHIFT];
    quot_back = 19'(quot_div) * 19'(DIV_441);
    rem_full  = num3 - quot_back;

    case (dmode3)
      DIV_NONE: begin
        quot4_next = num3[10:0];
        corr4_next = 1'b0;
      end
      DIV_HALF: begin
        quot4_next = num3[11:1];
        corr4_next = 1'b0;
      end
      default: begin
        quot4_next = quot_div;
        corr4_next = (rem_full >= 19'(DIV_441));
      end
    endcase

    bytes5_next = quot4 + 11'(corr4) + 11'(info4.pad);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= s_tvalid;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        v3 <= v2;
      end
      if (adv4) begin
        v4 <= v3;
      end
      if (adv5) begin
        v5 <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      info1  <= info1_next;
      mult1  <= mult1_next;
      dmode1 <= dmode1_next;
    end
    if (adv2) begin
      info2  <= info1;
      dmode2 <= dmode1;
      num2   <= num_full[18:0];
    end
    if (adv3) begin
      info3  <= info2;
      dmode3 <= dmode2;
      num3   <= num2;
      prod3  <= prod_next;
    end
    if (adv4) begin
      info4 <= info3;
      quot4 <= quot4_next;
      corr4 <= corr4_next;
    end
    if (adv5) begin
      // A refused header reports all fields as zero.
      if (info4.ok) begin
        info5  <= info4;
        bytes5 <= bytes5_next;
      end else begin
        info5  <= '0;
        bytes5 <= '0;
      end
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {4'b0000, bytes5, info5.samples, info5.chans, info5.rate,
                     info5.kbps, info5.version, info5.ok};

  // A refused header carries no other information.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !info5.ok) |-> (m_tdata == 56'd0))
    else $error("refused header with nonzero fields");

  // Frame length stays within range and never below the bitrate figure.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && info5.ok) |-> ((bytes5 <= 11'd1441) && (bytes5 >= 11'(info5.kbps))))
    else $error("frame length out of range");

  // The reciprocal quotient is at most one short of the true quotient.
  assert property (@(posedge clk) disable iff (rst)
    (v3 && (dmode3 == DIV_BY_441)) |-> (rem_full < 19'd882))
    else $error("reciprocal division off by more than one");

  // Samples per frame follow the reported version.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && info5.ok) |->
      ((info5.samples == SAMPLES_V1) == (info5.version == VER_OUT_V1)))
    else $error("samples per frame disagree with version");

endmodule

`default_nettype wire

// ===== dv/tb_mpeg_layer3_header_decode.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mpeg_layer3_header_decode: self-checking bench for the Layer III decoder
// Header words go in through a queued stream driver, and results are checked
// field by field against a built-in header decoder. The driver and receiver
// pause at random, and one long receiver hold-off backs up the pipeline.
// ----------------------------------------------------------------------------

module tb_mpeg_layer3_header_decode;
  import mlhd_pkg::*;

  typedef struct packed {
    logic        ok;
    logic [1:0]  version;
    logic [8:0]  kbps;
    logic [15:0] rate;
    logic [1:0]  chans;
    logic [10:0] samples;
    logic [10:0] bytes;
  } hdr_result_t;

  localparam int NUM_RANDOM = 1650;
  localparam int QUIET_LO   = 800;   // no pausing on either side in this window
  localparam int QUIET_HI   = 1100;
  localparam int HOLD_AT    = 300;
  localparam int HOLD_LEN   = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;

  logic [31:0] header_q[$];
  hdr_result_t decoded_q[$];
  int          taken_cnt = 0;
  int          got_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          err_cnt = 0;

  mpeg_layer3_header_decode u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Decodes one header word the way the block should.
  function automatic hdr_result_t decode_header(input logic [31:0] w);
    hdr_result_t r;
    logic [1:0]  ver_f;
    logic [1:0]  layer_f;
    logic [3:0]  bri_f;
    logic [1:0]  sri_f;
    int unsigned kb_v1;
    int unsigned kb_v2;
    int unsigned base_hz;
    int unsigned len;
    r = '0;
    ver_f   = w[20:19];
    layer_f = w[18:17];
    bri_f   = w[15:12];
    sri_f   = w[11:10];
    if (w[31:21] != 11'h7FF || ver_f == VER_CODE_RSVD || layer_f != LAYER_III_CODE ||
        bri_f == BRI_FREE || bri_f == BRI_BAD || sri_f == SRI_RSVD)
      return r;
    case (bri_f)
      4'd1:    begin kb_v1 = 32;  kb_v2 = 8;   end
      4'd2:    begin kb_v1 = 40;  kb_v2 = 16;  end
      4'd3:    begin kb_v1 = 48;  kb_v2 = 24;  end
      4'd4:    begin kb_v1 = 56;  kb_v2 = 32;  end
      4'd5:    begin kb_v1 = 64;  kb_v2 = 40;  end
      4'd6:    begin kb_v1 = 80;  kb_v2 = 48;  end
      4'd7:    begin kb_v1 = 96;  kb_v2 = 56;  end
      4'd8:    begin kb_v1 = 112; kb_v2 = 64;  end
      4'd9:    begin kb_v1 = 128; kb_v2 = 80;  end
      4'd10:   begin kb_v1 = 160; kb_v2 = 96;  end
      4'd11:   begin kb_v1 = 192; kb_v2 = 112; end
      4'd12:   begin kb_v1 = 224; kb_v2 = 128; end
      4'd13:   begin kb_v1 = 256; kb_v2 = 144; end
      default: begin kb_v1 = 320; kb_v2 = 160; end
    endcase
    case (sri_f)
      SRI_44K1: base_hz = 44100;
      SRI_48K:  base_hz = 48000;
      default:  base_hz = 32000;
    endcase
    r.ok = 1'b1;
    if (ver_f == VER_CODE_V1) begin
      r.version = VER_OUT_V1;
      r.kbps    = kb_v1[8:0];
      r.rate    = base_hz[15:0];
      r.samples = SAMPLES_V1;
    end else if (ver_f == VER_CODE_V2) begin
      r.version = VER_OUT_V2;
      r.kbps    = kb_v2[8:0];
      r.rate    = 16'(base_hz >> 1);
      r.samples = SAMPLES_OTHER;
    end else begin
      r.version = VER_OUT_V25;
      r.kbps    = kb_v2[8:0];
      r.rate    = 16'(base_hz >> 2);
      r.samples = SAMPLES_OTHER;
    end
    r.chans = (w[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
    len = (int'(r.samples) / 8) * int'(r.kbps) * 1000 / int'(r.rate) + int'(w[9]);
    r.bytes = len[10:0];
    return r;
  endfunction

  // Assembles a synced header; the ignored bits come from noise.
  function automatic logic [31:0] make_header(input logic [1:0] ver, input logic [1:0] layer,
                                              input logic [3:0] bri, input logic [1:0] sri,
                                              input logic pad, input logic [1:0] mode,
                                              input logic [31:0] noise);
    return {11'h7FF, ver, layer, noise[16], bri, sri, pad, noise[8], mode, noise[5:0]};
  endfunction

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // Sender: a new header may be offered once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        decoded_q.push_back(decode_header(s_tdata));
        taken_cnt <= taken_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (header_q.size() != 0 &&
            ((taken_cnt >= QUIET_LO && taken_cnt < QUIET_HI) || $urandom_range(99) >= 31)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= header_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (!hold_done && got_cnt >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= (got_cnt >= QUIET_LO && got_cnt < QUIET_HI) || $urandom_range(99) >= 31;
    end
  end

  always @(posedge clk) begin : result_mon
    hdr_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got_cnt <= got_cnt + 1;
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        check_field("header_ok", 32'(want.ok), 32'(m_tdata[0]));
        check_field("mpeg_version", 32'(want.version), 32'(m_tdata[2:1]));
        check_field("bitrate_kbps", 32'(want.kbps), 32'(m_tdata[11:3]));
        check_field("sample_rate_hz", 32'(want.rate), 32'(m_tdata[27:12]));
        check_field("channel_count", 32'(want.chans), 32'(m_tdata[29:28]));
        check_field("frame_samples", 32'(want.samples), 32'(m_tdata[40:30]));
        check_field("frame_bytes", 32'(want.bytes), 32'(m_tdata[51:41]));
      end
    end
  end

  initial begin
    logic [1:0]  ver;
    logic [31:0] w;
    // Directed headers: extremes, every refusal and the corners of the tables.
    header_q.push_back(32'h0000_0000);
    header_q.push_back(32'hFFFF_FFFF);
    w = make_header(VER_CODE_V1, LAYER_III_CODE, 4'd9, SRI_44K1, 1'b0, 2'd0, 32'h0);
    header_q.push_back(w);
    header_q.push_back(w ^ 32'h8000_0000);
    header_q.push_back(w ^ 32'h0020_0000);
    header_q.push_back(make_header(VER_CODE_V1, 2'd0, 4'd9, SRI_44K1, 1'b0, 2'd0, 32'h0));
    header_q.push_back(make_header(VER_CODE_V1, 2'd2, 4'd9, SRI_44K1, 1'b0, 2'd0, 32'h0));
    header_q.push_back(make_header(VER_CODE_V1, 2'd3, 4'd9, SRI_44K1, 1'b0, 2'd0, 32'h0));
    header_q.push_back(make_header(VER_CODE_RSVD, LAYER_III_CODE, 4'd9, SRI_44K1, 1'b0, 2'd0,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V1, LAYER_III_CODE, BRI_FREE, SRI_48K, 1'b0, 2'd1,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V2, LAYER_III_CODE, BRI_BAD, SRI_48K, 1'b0, 2'd1,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V25, LAYER_III_CODE, 4'd5, SRI_RSVD, 1'b1, 2'd2,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V1, LAYER_III_CODE, 4'd14, SRI_44K1, 1'b1,
                                   MODE_MONO, 32'hFFFF_FFFF));
    header_q.push_back(make_header(VER_CODE_V1, LAYER_III_CODE, 4'd1, SRI_32K, 1'b0, 2'd0,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V1, LAYER_III_CODE, 4'd14, SRI_48K, 1'b1, 2'd1,
                                   32'hFFFF_FFFF));
    header_q.push_back(make_header(VER_CODE_V2, LAYER_III_CODE, 4'd1, SRI_44K1, 1'b0, 2'd2,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V2, LAYER_III_CODE, 4'd14, SRI_32K, 1'b1,
                                   MODE_MONO, 32'h0));
    // Largest frame: MPEG-2.5 at 8 kHz, top bitrate, padded.
    header_q.push_back(make_header(VER_CODE_V25, LAYER_III_CODE, 4'd14, SRI_32K, 1'b1,
                                   MODE_MONO, 32'hFFFF_FFFF));
    header_q.push_back(make_header(VER_CODE_V25, LAYER_III_CODE, 4'd1, SRI_44K1, 1'b0, 2'd0,
                                   32'h0));
    header_q.push_back(make_header(VER_CODE_V25, LAYER_III_CODE, 4'd8, SRI_48K, 1'b1, 2'd2,
                                   32'h5A5A_5A5A));

    // Mostly well-formed headers; the rest are raw words or broken fields.
    repeat (NUM_RANDOM) begin
      case ($urandom_range(2))
        0:       ver = VER_CODE_V1;
        1:       ver = VER_CODE_V2;
        default: ver = VER_CODE_V25;
      endcase
      w = make_header(ver, LAYER_III_CODE, 4'($urandom_range(14, 1)), 2'($urandom_range(2)),
                      1'($urandom), 2'($urandom), $urandom);
      case ($urandom_range(19))
        0, 1:    w = $urandom;
        2:       w = w ^ (32'h1 << $urandom_range(31, 21));
        3, 4:    w[20:10] = 11'($urandom);
        default: ;
      endcase
      header_q.push_back(w);
    end

    @(negedge rst);
    while (header_q.size() != 0 || s_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
